// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the grid diffusion modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define GHD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// check that a condition never holds on a rising clock edge outside reset
`define GHD_NEVER(label, expr, msg) `GHD_ASSERT(label, !(expr), msg)

`endif

// File: hdl/ghd_pkg.sv
// ----------------------------------------------------------------------------
// ghd_pkg
// Shared widths, register codes and types of the grid heat diffusion step.
// ----------------------------------------------------------------------------
`default_nettype none

package ghd_pkg;

	localparam int TEMP_W       = 24;
	localparam int COEF_W       = 16;
	localparam int ROWS_W       = 11;
	localparam int COLS_W       = 6;
	localparam int DEF_MAX_COLS = 32;
	localparam int DEF_MAX_ROWS = 1024;

	localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd32;
	localparam logic [COLS_W-1:0] COLS_RESET = 6'd32;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPW         = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REG_COEF_ROW = 2'd0,
		REG_COEF_COL = 2'd1,
		REG_ROWS     = 2'd2,
		REG_COLS     = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		FE_RUN   = 1'b0,
		FE_DRAIN = 1'b1
	} fe_state_t;

	typedef struct packed {
		logic [ROWS_W-1:0] rows;
		logic [COLS_W-1:0] cols;
		logic              restart;
	} ghd_dims_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] t;
		logic signed [TEMP_W-1:0] up;
		logic signed [TEMP_W-1:0] down;
		logic signed [TEMP_W-1:0] left;
		logic signed [TEMP_W-1:0] right;
		logic                     last;
	} ghd_op_t;

endpackage

`default_nettype wire

// File: hdl/ghd_front.sv
// ----------------------------------------------------------------------------
// ghd_front
// Accepts old-frame cells, keeps the two line stores and the raster position,
// and gathers the five stencil operands of each cell to update, including the
// drain of the last row at the end of a frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ghd_front
	import ghd_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ghd_dims_t                dims,
	input  logic                     cell_valid,
	output logic                     cell_ready,
	input  logic signed [TEMP_W-1:0] temp_in,
	input  logic [QCW-1:0]           q_count,
	output logic                     q_push,
	output ghd_op_t                  q_op
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);

	fe_state_t state_q, state_nxt;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] last_col;
	logic [RW-1:0] last_row;
	logic [CW-1:0] addr_b;
	logic [QCW:0]  occ;
	logic          room;
	logic          issue_drain;
	logic          accept;
	logic          step;
	logic          end_of_frame;

	logic [TEMP_W-1:0] curr_mem [MAX_COLS];
	logic [TEMP_W-1:0] prev_mem [MAX_COLS];

	logic                     valid_s1;
	logic [CW-1:0]            addr_s1;
	logic                     first_s1;
	logic                     lastc_s1;
	logic                     mirror_s1;
	logic                     drain_s1;
	logic                     frame_last_s1;
	logic signed [TEMP_W-1:0] x_s1;
	logic signed [TEMP_W-1:0] rd_a_s1;
	logic signed [TEMP_W-1:0] rd_b_s1;
	logic signed [TEMP_W-1:0] rd_p_s1;
	logic signed [TEMP_W-1:0] held_q;

	always_comb begin
		if (dims.cols < COLS_W'(2)) begin
			last_col = CW'(1);
		end else if (dims.cols > MAX_COLS) begin
			last_col = CW'(MAX_COLS - 1);
		end else begin
			last_col = CW'(dims.cols - COLS_W'(1));
		end
	end

	always_comb begin
		if (dims.rows < ROWS_W'(2)) begin
			last_row = RW'(1);
		end else if (dims.rows > MAX_ROWS) begin
			last_row = RW'(MAX_ROWS - 1);
		end else begin
			last_row = RW'(dims.rows - ROWS_W'(1));
		end
	end

	assign occ          = {1'b0, q_count} + {{QCW{1'b0}}, valid_s1};
	assign room         = occ < (QCW + 1)'(QUEUE_DEPTH);
	assign accept       = cell_valid && cell_ready;
	assign step         = accept || issue_drain;
	assign end_of_frame = (row_q == last_row) && (col_q == last_col);

	always_comb begin
		if (col_q == '0) begin
			addr_b = CW'(1);
		end else if (col_q == last_col) begin
			addr_b = col_q;
		end else begin
			addr_b = col_q + CW'(1);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		if (dims.restart) begin
			state_nxt = FE_RUN;
		end else begin
			unique case (state_q)
				FE_RUN: begin
					if (accept && end_of_frame) begin
						state_nxt = FE_DRAIN;
					end
				end
				FE_DRAIN: begin
					if (issue_drain && (col_q == last_col)) begin
						state_nxt = FE_RUN;
					end
				end
				default: state_nxt = FE_RUN;
			endcase
		end
	end

	// outputs
	always_comb begin
		cell_ready  = 1'b0;
		issue_drain = 1'b0;
		unique case (state_q)
			FE_RUN:   cell_ready  = room;
			FE_DRAIN: issue_drain = room;
			default: begin
				cell_ready  = 1'b0;
				issue_drain = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FE_RUN;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			valid_s1 <= step && !(accept && (row_q == '0));
			if (dims.restart) begin
				col_q   <= '0;
				row_q   <= '0;
			end else if (step) begin
				if (col_q == last_col) begin
					col_q <= '0;
					if (accept) begin
						row_q <= (row_q == last_row) ? '0 : row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// line stores: read old values before the new word lands
	always_ff @(posedge clk) begin
		if (accept) begin
			curr_mem[col_q] <= temp_in;
		end
		if (step) begin
			rd_a_s1 <= curr_mem[col_q];
			rd_b_s1 <= curr_mem[addr_b];
			rd_p_s1 <= prev_mem[col_q];
		end
		if (valid_s1 && !drain_s1) begin
			prev_mem[addr_s1] <= rd_a_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			addr_s1       <= col_q;
			first_s1      <= col_q == '0;
			lastc_s1      <= col_q == last_col;
			mirror_s1     <= row_q == RW'(1);
			drain_s1      <= issue_drain;
			frame_last_s1 <= issue_drain && (col_q == last_col);
			x_s1          <= temp_in;
		end
		if (valid_s1) begin
			held_q <= rd_a_s1;
		end
	end

	always_comb begin
		q_op.t     = rd_a_s1;
		q_op.left  = first_s1 ? rd_b_s1 : held_q;
		q_op.right = lastc_s1 ? held_q : rd_b_s1;
		q_op.last  = frame_last_s1;
		if (drain_s1) begin
			q_op.up   = rd_p_s1;
			q_op.down = rd_p_s1;
		end else begin
			q_op.up   = mirror_s1 ? x_s1 : rd_p_s1;
			q_op.down = x_s1;
		end
	end

	assign q_push = valid_s1;

	`GHD_ASSERT(a_fe_drain_row, (state_q == FE_DRAIN) |-> (row_q == '0), "row moved in drain")
	`GHD_ASSERT(a_fe_last_drain, (valid_s1 && frame_last_s1) |-> drain_s1, "stray frame end")

endmodule

`default_nettype wire

// File: hdl/ghd_queue.sv
// ----------------------------------------------------------------------------
// ghd_queue
// Short operand queue between the gathering front and the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ghd_queue
	import ghd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ghd_op_t        push_op,
	input  logic           pop,
	output ghd_op_t        head,
	output logic           empty,
	output logic [QCW-1:0] count
);

	ghd_op_t        entry_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	assign head  = entry_q[rd_ptr_q];
	assign empty = count_q == '0;
	assign count = count_q;

	`GHD_NEVER(a_q_overflow, push && !pop && (count_q == QCW'(QUEUE_DEPTH)), "queue overflow")

endmodule

`default_nettype wire

// File: hdl/ghd_back.sv
// ----------------------------------------------------------------------------
// ghd_back
// Arithmetic pipeline: Laplacian terms, coefficient products, rounding,
// sum and saturation into the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ghd_back
	import ghd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [COEF_W-1:0]        coef_row,
	input  logic [COEF_W-1:0]        coef_col,
	input  ghd_op_t                  q_head,
	input  logic                     q_empty,
	output logic                     q_pop,
	output logic signed [TEMP_W-1:0] temp_out,
	output logic                     frame_last,
	output logic                     res_valid,
	input  logic                     res_ready
);

	localparam int LW = TEMP_W + 2;
	localparam int PW = LW + COEF_W + 1;
	localparam int RND_W = PW - COEF_W;
	localparam int SW = TEMP_W + 5;
	localparam logic signed [SW-1:0] SAT_HI = SW'(8388607);
	localparam logic signed [SW-1:0] SAT_LO = -SW'(8388608);
	localparam logic signed [PW-1:0] HALF = PW'(32768);

	logic adv;

	logic signed [LW-1:0]     lr;
	logic signed [LW-1:0]     lc;
	logic signed [COEF_W:0]   crow;
	logic signed [COEF_W:0]   ccol;
	logic signed [PW-1:0]     rnd_row;
	logic signed [PW-1:0]     rnd_col;
	logic signed [SW-1:0]     sum;

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [LW-1:0]     lr_s1, lc_s1;
	logic signed [TEMP_W-1:0] t_s1, t_s2, t_s3;
	logic                     last_s1, last_s2, last_s3;
	logic signed [PW-1:0]     prod_row_s2, prod_col_s2;
	logic signed [RND_W-1:0]  rnd_row_s3, rnd_col_s3;

	logic                     res_valid_q;
	logic signed [TEMP_W-1:0] temp_out_q;
	logic                     frame_last_q;

	assign adv   = !res_valid_q || res_ready;
	assign q_pop = adv && !q_empty;

	assign lr = {{2{q_head.up[TEMP_W-1]}}, q_head.up}
		+ {{2{q_head.down[TEMP_W-1]}}, q_head.down}
		- {q_head.t[TEMP_W-1], q_head.t, 1'b0};
	assign lc = {{2{q_head.left[TEMP_W-1]}}, q_head.left}
		+ {{2{q_head.right[TEMP_W-1]}}, q_head.right}
		- {q_head.t[TEMP_W-1], q_head.t, 1'b0};

	assign crow = $signed({1'b0, coef_row});
	assign ccol = $signed({1'b0, coef_col});

	// round to nearest, ties up
	assign rnd_row = prod_row_s2 + HALF;
	assign rnd_col = prod_col_s2 + HALF;

	assign sum = {{5{t_s3[TEMP_W-1]}}, t_s3}
		+ {{(SW-RND_W){rnd_row_s3[RND_W-1]}}, rnd_row_s3}
		+ {{(SW-RND_W){rnd_col_s3[RND_W-1]}}, rnd_col_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lr_s1       <= lr;
			lc_s1       <= lc;
			t_s1        <= q_head.t;
			last_s1     <= q_head.last;
			prod_row_s2 <= lr_s1 * crow;
			prod_col_s2 <= lc_s1 * ccol;
			t_s2        <= t_s1;
			last_s2     <= last_s1;
			rnd_row_s3  <= rnd_row[PW-1:COEF_W];
			rnd_col_s3  <= rnd_col[PW-1:COEF_W];
			t_s3        <= t_s2;
			last_s3     <= last_s2;
			frame_last_q <= last_s3;
			priority if (sum > SAT_HI) begin
				temp_out_q <= SAT_HI[TEMP_W-1:0];
			end else if (sum < SAT_LO) begin
				temp_out_q <= SAT_LO[TEMP_W-1:0];
			end else begin
				temp_out_q <= sum[TEMP_W-1:0];
			end
		end
	end

	assign temp_out   = temp_out_q;
	assign frame_last = frame_last_q;
	assign res_valid  = res_valid_q;

	`GHD_ASSERT(a_bk_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(t_s1)), "stage moved")

endmodule

`default_nettype wire

// File: hdl/grid_heat_diffusion_step.sv
// ----------------------------------------------------------------------------
// grid_heat_diffusion_step
// One explicit heat diffusion step over a raster-streamed temperature grid.
// Throughput: one cell per cycle unless the queue is full; after the frame's
//   last cell, input waits while the last row drains over the clamped columns.
// Path: the cell of the next row completes a result, which then passes the
//   front read stage, queue, three arithmetic stages and the output register.
// Reset: counters, queue and pipeline valids clear; line stores are not
//   cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_heat_diffusion_step
	import ghd_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     cell_valid,
	output logic                     cell_ready,
	input  logic signed [TEMP_W-1:0] temp_in,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic signed [TEMP_W-1:0] temp_out,
	output logic                     frame_last
);

	logic [COEF_W-1:0] coef_row_q;
	logic [COEF_W-1:0] coef_col_q;
	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic              wr;
	cfg_reg_t          reg_idx;
	ghd_dims_t         dims;

	logic           q_push;
	ghd_op_t        q_op;
	logic           q_pop;
	ghd_op_t        q_head;
	logic           q_empty;
	logic [QCW-1:0] q_count;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_idx = cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_row_q <= '0;
			coef_col_q <= '0;
			rows_q     <= ROWS_RESET;
			cols_q     <= COLS_RESET;
		end else if (wr) begin
			unique case (reg_idx)
				REG_COEF_ROW: coef_row_q <= pwdata[COEF_W-1:0];
				REG_COEF_COL: coef_col_q <= pwdata[COEF_W-1:0];
				REG_ROWS:     rows_q     <= pwdata[ROWS_W-1:0];
				REG_COLS:     cols_q     <= pwdata[COLS_W-1:0];
				default:      coef_row_q <= coef_row_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COEF_ROW: prdata = {16'd0, coef_row_q};
			REG_COEF_COL: prdata = {16'd0, coef_col_q};
			REG_ROWS:     prdata = {21'd0, rows_q};
			REG_COLS:     prdata = {26'd0, cols_q};
			default:      prdata = '0;
		endcase
	end

	// restart the frame on a dimension write
	assign dims.rows    = rows_q;
	assign dims.cols    = cols_q;
	assign dims.restart = wr && ((reg_idx == REG_ROWS) || (reg_idx == REG_COLS));

	ghd_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.dims       (dims),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.temp_in    (temp_in),
		.q_count    (q_count),
		.q_push     (q_push),
		.q_op       (q_op)
	);

	ghd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_op),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty),
		.count   (q_count)
	);

	ghd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_row   (coef_row_q),
		.coef_col   (coef_col_q),
		.q_head     (q_head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.temp_out   (temp_out),
		.frame_last (frame_last),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

endmodule

`default_nettype wire
